@@ sv/lr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lr_pkg
// Shared types and constants of the line rasterizer.
// ----------------------------------------------------------------------------
package lr_pkg;

  localparam int CFG_BITS     = 12;
  localparam int CFG_IDX_BITS = 2;
  localparam int COLOR_BITS   = 4;

  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_X     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Y     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_MAX_Y = 2'd2;

  localparam logic [CFG_BITS-1:0] ORIGIN_X_RST     = 12'd531;
  localparam logic [CFG_BITS-1:0] ORIGIN_Y_RST     = 12'd422;
  localparam logic [CFG_BITS-1:0] SCREEN_MAX_Y_RST = 12'd845;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef struct packed {
    logic [CFG_BITS-1:0] origin_x;
    logic [CFG_BITS-1:0] origin_y;
    logic [CFG_BITS-1:0] screen_max_y;
  } cfg_t;

  // pending pixel and line status
  typedef struct packed {
    logic valid;
    logic last;
    logic swap;
    logic mirror;
    logic busy;
  } pt_ctrl_t;

endpackage
`default_nettype wire

@@ sv/lr_cmd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lr_cmd_if
// Command channel: start or advance requests with endpoints and color.
// ----------------------------------------------------------------------------
interface lr_cmd_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [COORD_BITS-1:0] x0;
  logic [COORD_BITS-1:0] y0;
  logic [COORD_BITS-1:0] x1;
  logic [COORD_BITS-1:0] y1;
  logic [3:0]            color;

  modport source (output valid, op, x0, y0, x1, y1, color, input ready);
  modport sink   (input valid, op, x0, y0, x1, y1, color, output ready);
endinterface
`default_nettype wire

@@ sv/lr_pix_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lr_pix_if
// Pixel channel: screen coordinates, color and end-of-line flag.
// ----------------------------------------------------------------------------
interface lr_pix_if #(
  parameter int COORD_BITS = 12
);
  logic                    valid;
  logic                    ready;
  logic [COORD_BITS+1:0]   screen_x;
  logic [COORD_BITS+1:0]   screen_y;
  logic [3:0]              pixel_color;
  logic                    last;

  modport source (output valid, screen_x, screen_y, pixel_color, last, input ready);
  modport sink   (input valid, screen_x, screen_y, pixel_color, last, output ready);
endinterface
`default_nettype wire

@@ sv/lr_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lr_step
// Request register and Bresenham line state: line setup on start, one step
// per advance. The line state doubles as the pending pixel register.
// ----------------------------------------------------------------------------
module lr_step #(
  parameter int COORD_BITS = 12
) (
  input  wire                      clk,
  input  wire                      rst,
  lr_cmd_if.sink                   cmd,
  input  wire                      pt_take,
  output lr_pkg::pt_ctrl_t         pt_ctrl,
  output logic [COORD_BITS+1:0]    base_x,
  output logic [COORD_BITS+1:0]    base_y,
  output logic [COORD_BITS-1:0]    pt_u,
  output logic [COORD_BITS-1:0]    pt_v,
  output logic [3:0]               pt_color
);
  import lr_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int PW = COORD_BITS + 2;
  localparam int D  = COORD_BITS + 3;

  // request register
  logic                s1_valid;
  logic                s1_op;
  logic signed [C-1:0] s1_x0, s1_y0, s1_x1, s1_y1;
  logic [3:0]          s1_color;

  // line state
  logic [C-1:0]        len;
  logic signed [D-1:0] decision, step_straight, step_diagonal;

  pt_ctrl_t            pt_ctrl_next;
  logic [PW-1:0]       base_x_next, base_y_next;
  logic [C-1:0]        pt_u_next, pt_v_next, len_next;
  logic [3:0]          pt_color_next;
  logic signed [D-1:0] decision_next, step_straight_next, step_diagonal_next;

  logic                pt_free, go;

  // start setup
  logic signed [C-1:0] px, py, qx, qy;
  logic signed [C:0]   ddx, ddy;
  logic                fall, steep;
  logic [C-1:0]        dx, dy, maj, mnr;
  logic signed [D-1:0] maj_d, mnr_d;

  // advance
  logic [C-1:0]        u_inc;

  assign pt_free   = !pt_ctrl.valid || pt_take;
  assign go        = s1_valid && pt_free;
  assign cmd.ready = !s1_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_op    <= cmd.op;
      s1_x0    <= cmd.x0;
      s1_y0    <= cmd.y0;
      s1_x1    <= cmd.x1;
      s1_y1    <= cmd.y1;
      s1_color <= cmd.color;
    end
  end

  always_comb begin
    if (s1_x0 > s1_x1) begin
      px = s1_x1; py = s1_y1; qx = s1_x0; qy = s1_y0;
    end else begin
      px = s1_x0; py = s1_y0; qx = s1_x1; qy = s1_y1;
    end
    fall  = py > qy;
    ddx   = {qx[C-1], qx} - {px[C-1], px};
    ddy   = fall ? ({py[C-1], py} - {qy[C-1], qy}) : ({qy[C-1], qy} - {py[C-1], py});
    dx    = ddx[C-1:0];
    dy    = ddy[C-1:0];
    steep = dy > dx;
    maj   = steep ? dy : dx;
    mnr   = steep ? dx : dy;
    maj_d = {3'b000, maj};
    mnr_d = {3'b000, mnr};
  end

  assign u_inc = pt_u + 1'b1;

  always_comb begin
    pt_ctrl_next       = pt_ctrl;
    pt_ctrl_next.valid = pt_ctrl.valid && !pt_take;
    base_x_next        = base_x;
    base_y_next        = base_y;
    pt_u_next          = pt_u;
    pt_v_next          = pt_v;
    len_next           = len;
    pt_color_next      = pt_color;
    decision_next      = decision;
    step_straight_next = step_straight;
    step_diagonal_next = step_diagonal;
    if (go) begin
      if (s1_op == OP_START) begin
        pt_ctrl_next.valid  = 1'b1;
        pt_ctrl_next.last   = (maj == '0);
        pt_ctrl_next.busy   = (maj != '0);
        pt_ctrl_next.swap   = steep;
        pt_ctrl_next.mirror = fall;
        base_x_next         = {{2{px[C-1]}}, px};
        base_y_next         = {{2{py[C-1]}}, py};
        pt_u_next           = '0;
        pt_v_next           = '0;
        len_next            = maj;
        pt_color_next       = s1_color;
        decision_next       = (mnr_d <<< 1) - maj_d;
        step_straight_next  = mnr_d <<< 1;
        step_diagonal_next  = (mnr_d - maj_d) <<< 1;
      end else if (pt_ctrl.busy) begin
        pt_ctrl_next.valid = 1'b1;
        pt_ctrl_next.last  = (u_inc == len);
        pt_ctrl_next.busy  = (u_inc != len);
        pt_u_next          = u_inc;
        if (decision[D-1]) begin
          decision_next = decision + step_straight;
        end else begin
          pt_v_next     = pt_v + 1'b1;
          decision_next = decision + step_diagonal;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_ctrl <= '0;
    end else begin
      pt_ctrl <= pt_ctrl_next;
    end
  end

  always_ff @(posedge clk) begin
    base_x        <= base_x_next;
    base_y        <= base_y_next;
    pt_u          <= pt_u_next;
    pt_v          <= pt_v_next;
    len           <= len_next;
    pt_color      <= pt_color_next;
    decision      <= decision_next;
    step_straight <= step_straight_next;
    step_diagonal <= step_diagonal_next;
  end

endmodule
`default_nettype wire

@@ sv/lr_map.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lr_map
// Maps the pending pixel back from the normalized frame to screen
// coordinates and holds it in the output register.
// ----------------------------------------------------------------------------
module lr_map #(
  parameter int COORD_BITS = 12
) (
  input  wire                      clk,
  input  wire                      rst,
  input  lr_pkg::cfg_t             cfg,
  input  lr_pkg::pt_ctrl_t         pt_ctrl,
  input  wire [COORD_BITS+1:0]     base_x,
  input  wire [COORD_BITS+1:0]     base_y,
  input  wire [COORD_BITS-1:0]     pt_u,
  input  wire [COORD_BITS-1:0]     pt_v,
  input  wire [3:0]                pt_color,
  output logic                     pt_take,
  lr_pix_if.source                 pix
);
  import lr_pkg::*;

  localparam int PW = COORD_BITS + 2;

  logic [COORD_BITS-1:0] along, across;
  logic [PW-1:0]         org_x, org_y;
  logic [PW-1:0]         sx, sy;
  logic                  out_free;

  // first point in screen terms, with the registers as they are now
  assign org_x  = PW'(cfg.origin_x) + base_x;
  assign org_y  = PW'(cfg.screen_max_y) - PW'(cfg.origin_y) - base_y;

  assign along  = pt_ctrl.swap ? pt_v : pt_u;
  assign across = pt_ctrl.swap ? pt_u : pt_v;
  assign sx     = org_x + PW'(along);
  assign sy     = pt_ctrl.mirror ? (org_y + PW'(across)) : (org_y - PW'(across));

  assign out_free = !pix.valid || pix.ready;
  assign pt_take  = pt_ctrl.valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
    end else if (out_free) begin
      pix.valid <= pt_ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pt_take) begin
      pix.screen_x    <= sx;
      pix.screen_y    <= sy;
      pix.pixel_color <= pt_color;
      pix.last        <= pt_ctrl.last;
    end
  end

endmodule
`default_nettype wire

@@ sv/line_rasterizer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_rasterizer
// Bresenham line rasterizer for all octants, one pixel per request.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries requests. op = start takes two signed endpoints and a color
//   and yields the line's first pixel; op = advance yields the next pixel.
//   An advance with no line active yields nothing. A start drops any line
//   in progress. pix carries pixels in screen coordinates; last marks the
//   endpoint, and a line of n major-axis steps gives n+1 pixels.
//   cfg_we/cfg_index/cfg_data write origin_x, origin_y and screen_max_y;
//   write only while no request is in flight.
// Timing:
//   One request per cycle sustained while pix is not stalled; an accepted
//   request passes through the request register, then the combinational
//   step/setup logic into the line state, then the output register.
//   If pix is stalled, the pipeline fills and cmd.ready drops; nothing is
//   lost or repeated. Reset clears the pipeline, leaves no line active and
//   loads the register defaults.
// ----------------------------------------------------------------------------
module line_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  wire                              clk,
  input  wire                              rst,
  lr_cmd_if.sink                           cmd,
  lr_pix_if.source                         pix,
  input  wire                              cfg_we,
  input  wire [lr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire [lr_pkg::CFG_BITS-1:0]       cfg_data
);
  import lr_pkg::*;

  cfg_t                  cfg;
  pt_ctrl_t              pt_ctrl;
  logic [COORD_BITS+1:0] base_x, base_y;
  logic [COORD_BITS-1:0] pt_u, pt_v;
  logic [3:0]            pt_color;
  logic                  pt_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x     <= ORIGIN_X_RST;
      cfg.origin_y     <= ORIGIN_Y_RST;
      cfg.screen_max_y <= SCREEN_MAX_Y_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X:     cfg.origin_x     <= cfg_data;
        REG_ORIGIN_Y:     cfg.origin_y     <= cfg_data;
        REG_SCREEN_MAX_Y: cfg.screen_max_y <= cfg_data;
        default: ;
      endcase
    end
  end

  lr_step #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .pt_take  (pt_take),
    .pt_ctrl  (pt_ctrl),
    .base_x   (base_x),
    .base_y   (base_y),
    .pt_u     (pt_u),
    .pt_v     (pt_v),
    .pt_color (pt_color)
  );

  lr_map #(
    .COORD_BITS(COORD_BITS)
  ) u_map (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .pt_ctrl  (pt_ctrl),
    .base_x   (base_x),
    .base_y   (base_y),
    .pt_u     (pt_u),
    .pt_v     (pt_v),
    .pt_color (pt_color),
    .pt_take  (pt_take),
    .pix      (pix)
  );

  // a pending non-final pixel means the line is still active
  a_busy_vs_last: assert property (@(posedge clk) disable iff (rst)
    pt_ctrl.valid |-> (pt_ctrl.busy == !pt_ctrl.last))
    else $error("line status disagrees with pending pixel");

  a_take_fills_out: assert property (@(posedge clk) disable iff (rst)
    pt_take |=> pix.valid)
    else $error("pixel taken but output not valid");

  a_out_from_take: assert property (@(posedge clk) disable iff (rst)
    $rose(pix.valid) |-> $past(pt_take))
    else $error("output valid without a pending pixel");

endmodule
`default_nettype wire

@@ verif/line_rasterizer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_rasterizer_test
// Self-checking bench for the all-octant line rasterizer. Sends start and
// advance requests (directed corner lines, then mostly complete random lines
// of small size with some dropped, overrun or very long ones) under random
// request gaps and pixel stalls. Each accepted request is fed to a pixel
// predictor; every accepted pixel is compared against the oldest prediction.
// The origin and row-flip registers are changed between phases, extremes
// included.
// ----------------------------------------------------------------------------

localparam int LINE_COORD_BITS = 12;

typedef struct packed {
  logic                       op;
  logic [LINE_COORD_BITS-1:0] x0;
  logic [LINE_COORD_BITS-1:0] y0;
  logic [LINE_COORD_BITS-1:0] x1;
  logic [LINE_COORD_BITS-1:0] y1;
  logic [3:0]                 color;
} line_req_t;

typedef struct packed {
  logic [LINE_COORD_BITS+1:0] sx;
  logic [LINE_COORD_BITS+1:0] sy;
  logic [3:0]                 color;
  logic                       last;
} pixel_t;

class pixel_scoreboard;
  pixel_t expected_q[$];
  int errors;

  logic [lr_pkg::CFG_BITS-1:0] origin_x, origin_y, max_y;

  logic signed [13:0] work_x, work_y, end_x;
  logic signed [15:0] decision;
  logic signed [13:0] step_straight;
  logic signed [14:0] step_diag;
  logic signed [11:0] pivot_x, pivot_y;
  logic               mirror, swap, active;
  logic [3:0]         color;

  function new();
    errors        = 0;
    origin_x      = lr_pkg::ORIGIN_X_RST;
    origin_y      = lr_pkg::ORIGIN_Y_RST;
    max_y         = lr_pkg::SCREEN_MAX_Y_RST;
    work_x        = '0;
    work_y        = '0;
    end_x         = '0;
    decision      = '0;
    step_straight = '0;
    step_diag     = '0;
    pivot_x       = '0;
    pivot_y       = '0;
    mirror        = 1'b0;
    swap          = 1'b0;
    active        = 1'b0;
    color         = '0;
  endfunction

  function void flag(string msg);
    errors++;
    $error("%s", msg);
  endfunction

  function void set_reg(logic [lr_pkg::CFG_IDX_BITS-1:0] idx, logic [lr_pkg::CFG_BITS-1:0] val);
    case (idx)
      lr_pkg::REG_ORIGIN_X:     origin_x = val;
      lr_pkg::REG_ORIGIN_Y:     origin_y = val;
      lr_pkg::REG_SCREEN_MAX_Y: max_y    = val;
      default: ;
    endcase
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // map the normalized point back to logical, then to screen
  function void push_pixel(logic is_last);
    int     lx, ly, sx, sy;
    pixel_t p;
    lx = int'(work_x);
    ly = int'(work_y);
    if (swap) begin
      lx = int'(pivot_x) + (int'(work_y) - int'(pivot_y));
      ly = int'(pivot_y) + (int'(work_x) - int'(pivot_x));
    end
    if (mirror)
      ly = 2 * int'(pivot_y) - ly;
    sx = lx + int'(origin_x);
    sy = int'(max_y) - (ly + int'(origin_y));
    p.sx    = 14'(sx);
    p.sy    = 14'(sy);
    p.color = color;
    p.last  = is_last;
    expected_q.push_back(p);
  endfunction

  function void note_request(line_req_t r);
    int ax, ay, bx, by, px, py, qx, qy, dx, dy, t;
    if (r.op == lr_pkg::OP_START) begin
      ax = int'($signed(r.x0));
      ay = int'($signed(r.y0));
      bx = int'($signed(r.x1));
      by = int'($signed(r.y1));
      if (ax <= bx) begin
        px = ax; py = ay; qx = bx; qy = by;
      end else begin
        px = bx; py = by; qx = ax; qy = ay;
      end
      mirror = (py > qy);
      if (mirror)
        qy = 2 * py - qy;
      dx = qx - px;
      dy = qy - py;
      swap = (dy > dx);
      if (swap) begin
        t = dx; dx = dy; dy = t;
      end
      pivot_x       = 12'(px);
      pivot_y       = 12'(py);
      work_x        = 14'(px);
      work_y        = 14'(py);
      end_x         = 14'(px + dx);
      step_straight = 14'(2 * dy);
      step_diag     = 15'(2 * (dy - dx));
      decision      = 16'(2 * dy - dx);
      color         = r.color;
      active        = (dx != 0);
      push_pixel(dx == 0);
    end else if (active) begin
      work_x = work_x + 14'sd1;
      if (decision < 0) begin
        decision = decision + 16'(step_straight);
      end else begin
        work_y   = work_y + 14'sd1;
        decision = decision + 16'(step_diag);
      end
      if (work_x >= end_x)
        active = 1'b0;
      push_pixel(!active);
    end
  endfunction

  function void check_pixel(pixel_t got);
    pixel_t exp;
    if (expected_q.size() == 0) begin
      flag($sformatf("unexpected pixel x=%0d y=%0d", $signed(got.sx), $signed(got.sy)));
      return;
    end
    exp = expected_q.pop_front();
    if (got.sx !== exp.sx)
      flag($sformatf("screen_x: expected %0d, got %0d", $signed(exp.sx), $signed(got.sx)));
    if (got.sy !== exp.sy)
      flag($sformatf("screen_y: expected %0d, got %0d", $signed(exp.sy), $signed(got.sy)));
    if (got.color !== exp.color)
      flag($sformatf("pixel_color: expected %0d, got %0d", exp.color, got.color));
    if (got.last !== exp.last)
      flag($sformatf("last: expected %0d, got %0d", exp.last, got.last));
  endfunction
endclass

module line_rasterizer_test;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [lr_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [lr_pkg::CFG_BITS-1:0]     cfg_data = '0;
  logic pix_ready = 1'b0;
  int   idle_pct = 16;

  pixel_scoreboard sb = new();

  lr_cmd_if #(.COORD_BITS(LINE_COORD_BITS)) cmd ();
  lr_pix_if #(.COORD_BITS(LINE_COORD_BITS)) pix ();

  assign pix.ready = pix_ready;

  line_rasterizer #(.COORD_BITS(LINE_COORD_BITS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .pix       (pix),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    pix_ready <= ($urandom_range(0, 99) >= idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && cmd.valid && cmd.ready)
      sb.note_request({cmd.op, cmd.x0, cmd.y0, cmd.x1, cmd.y1, cmd.color});
    if (!rst && pix.valid && pix.ready)
      sb.check_pixel({pix.screen_x, pix.screen_y, pix.pixel_color, pix.last});
  end

  function automatic int clip(int v);
    if (v < -2048) return -2048;
    if (v > 2047)  return 2047;
    return v;
  endfunction

  task automatic send_req(input line_req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.op    <= r.op;
    cmd.x0    <= r.x0;
    cmd.y0    <= r.y0;
    cmd.x1    <= r.x1;
    cmd.y1    <= r.y1;
    cmd.color <= r.color;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
  endtask

  task automatic start_line(input int x0, input int y0, input int x1, input int y1,
                            input logic [3:0] color);
    line_req_t r;
    r.op    = lr_pkg::OP_START;
    r.x0    = x0[11:0];
    r.y0    = y0[11:0];
    r.x1    = x1[11:0];
    r.y1    = y1[11:0];
    r.color = color;
    send_req(r);
  endtask

  // endpoint and color fields carry noise on advance
  task automatic advance(input int n);
    line_req_t   r;
    logic [63:0] noise;
    repeat (n) begin
      noise   = {$urandom, $urandom};
      r       = noise[$bits(line_req_t)-1:0];
      r.op    = lr_pkg::OP_ADVANCE;
      send_req(r);
    end
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    cmd.valid <= 1'b0;
    while (sb.pending() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending() != 0) begin
      sb.flag($sformatf("%0d pixels never arrived", sb.pending()));
      sb.expected_q.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input logic [11:0] ox, input logic [11:0] oy, input logic [11:0] my);
    logic [lr_pkg::CFG_IDX_BITS-1:0] idx [3];
    logic [lr_pkg::CFG_BITS-1:0]     val [3];
    idx = '{lr_pkg::REG_ORIGIN_X, lr_pkg::REG_ORIGIN_Y, lr_pkg::REG_SCREEN_MAX_Y};
    val = '{ox, oy, my};
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_line(inout int produced);
    int ax, ay, bx, by, span, major, n, pick;
    pick = $urandom_range(0, 99);
    if (pick < 5)       span = 0;
    else if (pick < 82) span = 12;
    else if (pick < 96) span = 200;
    else                span = 4095;
    ax = int'($urandom_range(0, 4095)) - 2048;
    ay = int'($urandom_range(0, 4095)) - 2048;
    bx = clip(ax + int'($urandom_range(0, 2 * span)) - span);
    by = clip(ay + int'($urandom_range(0, 2 * span)) - span);
    major = (bx > ax) ? bx - ax : ax - bx;
    if (((by > ay) ? by - ay : ay - by) > major)
      major = (by > ay) ? by - ay : ay - by;
    pick = $urandom_range(0, 9);
    if (pick == 0)      n = $urandom_range(0, major);
    else if (pick == 1) n = major + $urandom_range(1, 3);
    else                n = major;
    if (n > 300)
      n = $urandom_range(0, 40);
    start_line(ax, ay, bx, by, 4'($urandom_range(0, 15)));
    advance(n);
    produced += 1 + ((n < major) ? n : major);
  endtask

  initial begin
    int produced;
    cmd.valid <= 1'b0;
    cmd.op    <= lr_pkg::OP_START;
    cmd.x0    <= '0;
    cmd.y0    <= '0;
    cmd.x1    <= '0;
    cmd.y1    <= '0;
    cmd.color <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // corner cases under reset register values
    advance(1);
    start_line(0, 0, 0, 0, 4'd0);
    start_line(-2048, -2048, 2047, 2047, 4'd15);
    advance(2);
    start_line(2047, -2048, -2048, 2047, 4'd9);
    advance(1);
    start_line(0, 2, 0, 0, 4'd3);
    advance(2);
    start_line(3, -1, 0, 1, 4'd12);
    advance(3);
    start_line(0, 0, 1, -3, 4'd5);
    advance(4);
    start_line(2047, -2048, 2047, -2048, 4'd10);
    start_line(-2048, 2047, -2048, 2047, 4'd6);
    settle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       set_config(12'd0, 12'd0, 12'd0);
        1:       set_config(12'hFFF, 12'hFFF, 12'hFFF);
        2:       set_config(12'hFFF, 12'd0, 12'd479);
        default: set_config(12'($urandom), 12'($urandom), 12'($urandom));
      endcase
      idle_pct = (phase == 3) ? 0 : 16;
      produced = 0;
      while (produced < 210)
        random_line(produced);
      settle();
    end

    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
